// ----- src/assert_macros.svh -----
// Assertion macros shared by the generator RTL.
// Depends on a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/mtg_pkg.sv -----
// Shared types, constants and helpers of the MT19937 generator.
// No dependencies; the interfaces, the core, the remainder unit and the top level import this package.
package mtg_pkg;

  localparam int WORD_W      = 32;
  localparam int STATE_WORDS = 624;
  localparam int SHIFT_M     = 397;
  localparam int ADDR_W      = $clog2(STATE_WORDS);
  localparam int IDX_W       = $clog2(STATE_WORDS + 2);
  localparam int DIV_CNT_W   = $clog2(WORD_W);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam idx_t LAST_IDX     = idx_t'(STATE_WORDS - 1);
  localparam idx_t TWIST_IDX    = idx_t'(STATE_WORDS);
  localparam idx_t UNSEEDED_IDX = idx_t'(STATE_WORDS + 1);
  localparam idx_t FAR_OFS      = idx_t'(SHIFT_M);
  localparam idx_t WRAP_OFS     = idx_t'(STATE_WORDS - SHIFT_M);

  localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(WORD_W - 1);

  localparam word_t MATRIX_A   = 32'h9908_B0DF;
  localparam word_t FILL_MULT  = 32'h6C07_8965;
  localparam word_t TEMPER_B   = 32'h9D2C_5680;
  localparam word_t TEMPER_C   = 32'hEFC6_0000;
  localparam word_t UPPER_MASK = 32'h8000_0000;
  localparam word_t LOWER_MASK = 32'h7FFF_FFFF;
  localparam word_t SEED_RESET = 32'd5489;
  localparam word_t MIN_BOUND  = 32'd2;

  localparam logic OP_RAW     = 1'b0;
  localparam logic OP_UNIFORM = 1'b1;

  typedef enum logic [2:0] {
    CORE_IDLE,
    CORE_FILL_MUL,
    CORE_FILL_ADD,
    CORE_TW_PRE,
    CORE_TW_RD,
    CORE_TW_WR,
    CORE_RD,
    CORE_OUT
  } core_state_t;

  typedef enum logic [2:0] {
    CTL_IDLE,
    CTL_FLOOR,
    CTL_DRAW,
    CTL_WAIT,
    CTL_MOD,
    CTL_DONE
  } ctl_state_t;

  typedef struct packed {
    logic  draw;
    logic  reseed;
    word_t seed;
  } gen_ctl_t;

  typedef struct packed {
    logic  idle;
    logic  valid;
    word_t word;
  } word_rsp_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    word_t rem;
  } div_rsp_t;

  function automatic word_t temper(word_t w);
    word_t r;
    r = w;
    r = r ^ (r >> 11);
    r = r ^ ((r << 7) & TEMPER_B);
    r = r ^ ((r << 15) & TEMPER_C);
    r = r ^ (r >> 18);
    return r;
  endfunction

endpackage

// ----- src/mtg_req_if.sv -----
// Request channel of the generator: opcode and bound with valid/ready.
// Depends on mtg_pkg.
interface mtg_req_if import mtg_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  opcode;
  word_t limit;

  modport source (output valid, output opcode, output limit, input ready);
  modport sink   (input valid, input opcode, input limit, output ready);
endinterface

// ----- src/mtg_rsp_if.sv -----
// Result channel of the generator: one 32-bit value with valid/ready.
// Depends on mtg_pkg.
interface mtg_rsp_if import mtg_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// ----- src/mtg_ram.sv -----
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module mtg_ram #(
  parameter int DEPTH = 624,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- src/mtg_divider.sv -----
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on mtg_pkg.
module mtg_divider import mtg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  word_t                rem;
  word_t                dvd;
  word_t                dsr;

  logic [WORD_W:0] trial;
  logic [WORD_W:0] diff;
  word_t           rem_next;

  always_comb begin
    trial    = {rem, dvd[WORD_W-1]};
    diff     = trial - {1'b0, dsr};
    rem_next = diff[WORD_W] ? trial[WORD_W-1:0] : diff[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= dvd << 1;
    end
  end

  assign rsp = '{busy: busy, done: done, rem: rem};

endmodule

// ----- src/mtg_core.sv -----
// State-word sequencer: seed fill, in-place twist and tempered reads.
// Depends on mtg_pkg and mtg_ram.
module mtg_core import mtg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  gen_ctl_t  ctl,
  output word_rsp_t rsp
);

  core_state_t state, state_next;
  idx_t        idx, idx_next;
  idx_t        k, k_next;
  word_t       prev, prev_next;
  word_t       prod, prod_next;
  word_t       cur, cur_next;

  logic  we;
  addr_t waddr;
  word_t wdata;
  addr_t raddr_a;
  addr_t raddr_b;
  word_t rd_a;
  word_t rd_b;

  idx_t  nxt_k;
  idx_t  far_k;
  word_t y;
  word_t twisted;
  word_t fill_word;

  mtg_ram #(
    .DEPTH(STATE_WORDS),
    .WIDTH(WORD_W)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_comb begin
    nxt_k     = (k == LAST_IDX) ? '0 : k + 1'b1;
    far_k     = (k >= WRAP_OFS) ? k - WRAP_OFS : k + FAR_OFS;
    y         = (cur & UPPER_MASK) | (rd_a & LOWER_MASK);
    twisted   = rd_b ^ (y >> 1) ^ (y[0] ? MATRIX_A : '0);
    fill_word = prod + word_t'(k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CORE_IDLE;
      idx   <= UNSEEDED_IDX;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    k    <= k_next;
    prev <= prev_next;
    prod <= prod_next;
    cur  <= cur_next;
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    k_next     = k;
    prev_next  = prev;
    prod_next  = prod;
    cur_next   = cur;
    we         = 1'b0;
    waddr      = k[ADDR_W-1:0];
    wdata      = fill_word;
    raddr_a    = '0;
    raddr_b    = '0;
    unique case (state)
      CORE_IDLE: begin
        if (ctl.draw) begin
          if (idx == UNSEEDED_IDX) begin
            we         = 1'b1;
            waddr      = '0;
            wdata      = ctl.seed;
            prev_next  = ctl.seed;
            k_next     = idx_t'(1);
            state_next = CORE_FILL_MUL;
          end else if (idx == TWIST_IDX) begin
            state_next = CORE_TW_PRE;
          end else begin
            state_next = CORE_RD;
          end
        end
      end
      CORE_FILL_MUL: begin
        prod_next  = FILL_MULT * (prev ^ (prev >> 30));
        state_next = CORE_FILL_ADD;
      end
      CORE_FILL_ADD: begin
        we        = 1'b1;
        prev_next = fill_word;
        if (k == LAST_IDX) begin
          idx_next   = TWIST_IDX;
          state_next = CORE_TW_PRE;
        end else begin
          k_next     = k + 1'b1;
          state_next = CORE_FILL_MUL;
        end
      end
      CORE_TW_PRE: begin
        k_next     = '0;
        state_next = CORE_TW_RD;
      end
      CORE_TW_RD: begin
        raddr_a = nxt_k[ADDR_W-1:0];
        raddr_b = far_k[ADDR_W-1:0];
        if (k == '0) begin
          cur_next = rd_a;
        end
        state_next = CORE_TW_WR;
      end
      CORE_TW_WR: begin
        we       = 1'b1;
        wdata    = twisted;
        cur_next = rd_a;
        if (k == LAST_IDX) begin
          idx_next   = '0;
          state_next = CORE_RD;
        end else begin
          k_next     = k + 1'b1;
          state_next = CORE_TW_RD;
        end
      end
      CORE_RD: begin
        raddr_a    = idx[ADDR_W-1:0];
        idx_next   = idx + 1'b1;
        state_next = CORE_OUT;
      end
      CORE_OUT: begin
        state_next = CORE_IDLE;
      end
      default: begin
        state_next = CORE_IDLE;
      end
    endcase
    if (ctl.reseed) begin
      idx_next = UNSEEDED_IDX;
    end
  end

  assign rsp = '{idle: (state == CORE_IDLE), valid: (state == CORE_OUT), word: temper(rd_a)};

endmodule

// ----- src/mt19937_generator.sv -----
// MT19937 generator top level: request control, rejection sampling, result register.
// Depends on mtg_pkg, mtg_req_if, mtg_rsp_if, mtg_core, mtg_divider, assert_macros.svh.
//
// One request gives one 32-bit word. A raw request (opcode 0) passes through
// the draw, wait and done states to the output register when the state needs no
// refresh. Every 624th word the state is twisted in place first, with two memory
// reads and one write per state word; the first request after reset or a seed
// write also refills the state from the seed, one state word per pass through the
// fill multiplier. A uniform request (opcode 1) with a bound of 2 or more first
// computes the rejection floor in the remainder unit, redraws while a word is
// below it, and then takes the final remainder of the word by the bound; a bound
// under 2 returns 0. A new request is taken while the previous result waits in
// the output register. There is no clearing pass after reset.
`include "assert_macros.svh"

module mt19937_generator import mtg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mtg_req_if.sink    request,
  mtg_rsp_if.source  result,
  input  logic       seed_write,
  input  word_t      seed_data
);

  ctl_state_t state, state_next;
  logic       op, op_next;
  word_t      bound, bound_next;
  word_t      floor_val, floor_next;
  word_t      res, res_next;
  word_t      seed;
  logic       out_valid;
  word_t      out_value;
  logic       load;
  logic       draw;

  gen_ctl_t  gen_ctl;
  word_rsp_t word_rsp;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (seed_write) begin
      seed <= seed_data;
    end
  end

  assign gen_ctl = '{draw: draw, reseed: seed_write, seed: seed};

  mtg_core u_core (
    .clk (clk),
    .rst (rst),
    .ctl (gen_ctl),
    .rsp (word_rsp)
  );

  mtg_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CTL_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    bound     <= bound_next;
    floor_val <= floor_next;
    res       <= res_next;
    if (load) begin
      out_value <= res;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    bound_next = bound;
    floor_next = floor_val;
    res_next   = res;
    load       = 1'b0;
    draw       = 1'b0;
    div_req    = '{start: 1'b0, dividend: word_rsp.word, divisor: bound};
    unique case (state)
      CTL_IDLE: begin
        if (request.valid) begin
          op_next    = request.opcode;
          bound_next = request.limit;
          if (request.opcode == OP_RAW) begin
            state_next = CTL_DRAW;
          end else if (request.limit < MIN_BOUND) begin
            res_next   = '0;
            state_next = CTL_DONE;
          end else begin
            div_req    = '{start: 1'b1, dividend: word_t'(0) - request.limit,
                           divisor: request.limit};
            state_next = CTL_FLOOR;
          end
        end
      end
      CTL_FLOOR: begin
        if (div_rsp.done) begin
          floor_next = div_rsp.rem;
          state_next = CTL_DRAW;
        end
      end
      CTL_DRAW: begin
        draw       = 1'b1;
        state_next = CTL_WAIT;
      end
      CTL_WAIT: begin
        if (word_rsp.valid) begin
          if (op == OP_RAW) begin
            res_next   = word_rsp.word;
            state_next = CTL_DONE;
          end else if (word_rsp.word < floor_val) begin
            state_next = CTL_DRAW;
          end else begin
            div_req.start = 1'b1;
            state_next    = CTL_MOD;
          end
        end
      end
      CTL_MOD: begin
        if (div_rsp.done) begin
          res_next   = div_rsp.rem;
          state_next = CTL_DONE;
        end
      end
      CTL_DONE: begin
        if (!out_valid || result.ready) begin
          load       = 1'b1;
          state_next = CTL_IDLE;
        end
      end
      default: begin
        state_next = CTL_IDLE;
      end
    endcase
  end

  assign request.ready = (state == CTL_IDLE);
  assign result.valid  = out_valid;
  assign result.value  = out_value;

  `ASSERT_IMPL(a_draw_core_idle, gen_ctl.draw, word_rsp.idle, "draw while state sequencer busy")
  `ASSERT_IMPL(a_div_free, div_req.start, !div_rsp.busy, "remainder start while busy")
  `ASSERT_IMPL(a_word_expected, word_rsp.valid, state == CTL_WAIT, "word with no draw pending")
  `ASSERT_NEXT(a_load_shown, load, result.valid && (result.value == $past(res)), "result not loaded")

endmodule
